/* sv/datt_pkg.sv */
// ----------------------------------------------------------------------------
// datt_pkg
// shared types, widths and codes of the dual accelerometer turn angle tracker
// ----------------------------------------------------------------------------
package datt_pkg;

    // field widths
    localparam int ACT_W     = 2;
    localparam int SAMP_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ANGLE_W   = 32;

    // default width of the running angle
    localparam int ANGLE_BITS_DEF = 32;

    // datapath widths
    localparam int FRAC_SH    = 24;                 // diff scaled into q.24 before divide
    localparam int DIV_W      = SAMP_W + FRAC_SH;   // dividend and quotient
    localparam int DIV_STEPS  = DIV_W;
    localparam int ROOT_W     = (DIV_W + 16) / 2;   // root of ratio * 2^16
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SUB_W      = ROOT_W + 2;         // shared compare / subtract width
    localparam int WS_W       = 2 * CFG_W;          // wait_ticks * step_scale
    localparam int PROD_W     = ROOT_W + WS_W;
    localparam int INC_W      = PROD_W - 16;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // action codes
    localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SPACING = 16'd256;
    localparam logic [CFG_W-1:0] RST_WAIT    = 16'd1;
    localparam logic [CFG_W-1:0] RST_STEP    = 16'd65535;

    // tracker protocol phase
    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_WAIT_LEFT  = 5'b00010,
        PH_WAIT_RIGHT = 5'b00100,
        PH_WAIT_ACK   = 5'b01000,
        PH_WAITING    = 5'b10000
    } t_phase;

    // arithmetic sequencer
    typedef enum logic [4:0] {
        SQ_IDLE = 5'b00001,
        SQ_DIV  = 5'b00010,
        SQ_SQRT = 5'b00100,
        SQ_MUL  = 5'b01000,
        SQ_ACC  = 5'b10000
    } t_seq;

    // shared unit operands and result
    typedef struct packed {
        logic [SUB_W-1:0] a;
        logic [SUB_W-1:0] b;
    } t_sub_req;

    typedef struct packed {
        logic             ge;
        logic [SUB_W-1:0] diff;
    } t_sub_res;

endpackage

/* sv/datt_in_if.sv */
// ----------------------------------------------------------------------------
// datt_in_if
// input channel: action code and y acceleration sample
// ----------------------------------------------------------------------------
interface datt_in_if;
    logic                                valid;
    logic                                ready;
    logic [datt_pkg::ACT_W-1:0]          action;
    logic signed [datt_pkg::SAMP_W-1:0]  accel_y;

    modport source (output valid, output action, output accel_y, input ready);
    modport sink   (input valid, input action, input accel_y, output ready);
endinterface

/* sv/datt_out_if.sv */
// ----------------------------------------------------------------------------
// datt_out_if
// result channel: sample acknowledge and emitted angle
// ----------------------------------------------------------------------------
interface datt_out_if;
    logic                                valid;
    logic                                ready;
    logic                                sample_taken;
    logic                                angle_valid;
    logic signed [datt_pkg::ANGLE_W-1:0] angle_out;

    modport source (output valid, output sample_taken, output angle_valid,
                    output angle_out, input ready);
    modport sink   (input valid, input sample_taken, input angle_valid,
                    input angle_out, output ready);
endinterface

/* sv/datt_cmp_sub.sv */
// ----------------------------------------------------------------------------
// datt_cmp_sub
// shared compare and subtract unit for the divide and square root steps
// ----------------------------------------------------------------------------
module datt_cmp_sub (
    input  datt_pkg::t_sub_req i_req,
    output datt_pkg::t_sub_res o_res
);
    import datt_pkg::*;

    logic [SUB_W:0] w_wide;

    // borrow out of the top bit means a < b
    assign w_wide     = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_res.ge   = ~w_wide[SUB_W];
    assign o_res.diff = w_wide[SUB_W-1:0];

endmodule

/* sv/dual_accel_turn_angle_tracker_top.sv */
// ----------------------------------------------------------------------------
// dual_accel_turn_angle_tracker_top
// turn angle estimate from the y samples of two accelerometers
// ----------------------------------------------------------------------------
// result: a transaction that does not complete a sample pair gives its result
//   in the cycle after acceptance; the one that completes a pair gives it after
//   40 divide steps, 28 root steps, a multiply and an accumulate
// throughput: one transaction at a time; divide and root share one compare / subtract unit
// reset: i_rst_n synchronous active low; clears phase, samples, angle, tick
//   count, result valid, and loads the register reset values
// ----------------------------------------------------------------------------
module dual_accel_turn_angle_tracker_top #(
    parameter int ANGLE_BITS = datt_pkg::ANGLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [datt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [datt_pkg::CFG_W-1:0]       i_cfg_data,
    datt_in_if.sink                          i_in,
    datt_out_if.source                       o_out
);
    import datt_pkg::*;

    // accumulate width holds the angle plus the increment with a carry
    localparam int SUM_W = ((ANGLE_BITS > INC_W) ? ANGLE_BITS : INC_W) + 1;
    // extension width for taking the low bits of the output angle
    localparam int EXT_W = (ANGLE_BITS > ANGLE_W) ? ANGLE_BITS : ANGLE_W;
    localparam logic [SUM_W-1:0] MAX_V = (SUM_W'(1) << (ANGLE_BITS - 1)) - SUM_W'(1);

    // configuration registers
    logic [CFG_W-1:0] r_spacing;
    logic [CFG_W-1:0] r_wait;
    logic [CFG_W-1:0] r_step;

    // tracker state
    t_phase                   r_phase, n_phase;
    logic signed [SAMP_W-1:0] r_left, n_left;
    logic signed [SAMP_W-1:0] r_right, n_right;
    logic [ANGLE_BITS-1:0]    r_run, n_run;
    logic [CFG_W-1:0]         r_tick, n_tick;

    // sequencer and datapath
    t_seq              r_seq;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_quo;    // dividend in, quotient out, then root operand source
    logic [SUB_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [WS_W-1:0]   r_ws;
    logic [PROD_W-1:0] r_prod;

    // result register
    logic                      r_out_valid;
    logic                      r_taken;
    logic                      r_avalid;
    logic signed [ANGLE_W-1:0] r_angle;

    logic                      w_accept;
    logic                      w_taken;
    logic                      w_start;
    logic signed [SAMP_W:0]    w_d;
    logic [SAMP_W:0]           w_abs;
    logic [CFG_W-1:0]          w_div;
    t_sub_req                  w_req;
    t_sub_res                  w_res;
    logic [SUM_W-1:0]          w_sum;
    logic [EXT_W-1:0]          w_run_ext;
    logic [ANGLE_W-1:0]        w_run32;
    logic signed [ANGLE_W-1:0] w_angle;

    // a new transaction is taken when the sequencer is free and the
    // result register is empty or being drained this cycle
    assign i_in.ready = (r_seq == SQ_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.sample_taken = r_taken;
    assign o_out.angle_valid  = r_avalid;
    assign o_out.angle_out    = r_angle;

    // protocol phase update for the offered transaction
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_right = r_right;
        n_tick  = r_tick;
        w_taken = 1'b0;
        unique case (i_in.action)
            ACT_RIGHT: begin
                if (r_phase == PH_IDLE || r_phase == PH_WAIT_RIGHT) begin
                    n_right = i_in.accel_y;
                    w_taken = 1'b1;
                    n_phase = (r_phase == PH_IDLE) ? PH_WAIT_LEFT : PH_WAIT_ACK;
                end
            end
            ACT_LEFT: begin
                if (r_phase == PH_IDLE || r_phase == PH_WAIT_LEFT) begin
                    n_left  = i_in.accel_y;
                    w_taken = 1'b1;
                    n_phase = (r_phase == PH_IDLE) ? PH_WAIT_RIGHT : PH_WAIT_ACK;
                end
            end
            ACT_ACK: begin
                if (r_phase == PH_WAIT_ACK) begin
                    n_tick  = '0;
                    n_phase = (r_wait == '0) ? PH_IDLE : PH_WAITING;
                end
            end
            ACT_TICK: begin
                if (r_phase == PH_WAITING) begin
                    // a shortened wait rearms on the first tick past the limit
                    if (r_tick < r_wait) begin
                        n_tick = r_tick + CFG_W'(1);
                    end
                    if (n_tick >= r_wait) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // second sample of a pair starts the arithmetic
    assign w_start = w_accept && w_taken && (n_phase == PH_WAIT_ACK);

    // |left - right| from the values being stored
    assign w_d   = (SAMP_W + 1)'(n_left) - (SAMP_W + 1)'(n_right);
    assign w_abs = w_d[SAMP_W] ? (SAMP_W + 1)'(-w_d) : w_d;

    // zero spacing counts as one
    assign w_div = (r_spacing == '0) ? CFG_W'(1) : r_spacing;

    // operand select for the shared unit
    always_comb begin
        if (r_seq == SQ_SQRT) begin
            // remainder with the next two operand bits vs. 4 * root + 1
            w_req.a = {r_rem[SUB_W-3:0], r_quo[DIV_W-1 -: 2]};
            w_req.b = {r_root, 2'b01};
        end else begin
            // remainder with the next dividend bit vs. spacing
            w_req.a = SUB_W'({r_rem[CFG_W-1:0], r_quo[DIV_W-1]});
            w_req.b = SUB_W'(w_div);
        end
    end

    datt_cmp_sub u_cmp_sub (
        .i_req (w_req),
        .o_res (w_res)
    );

    // accumulate with saturation at the largest positive angle
    assign w_sum     = SUM_W'(r_run) + SUM_W'(r_prod[PROD_W-1:16]);
    assign n_run     = (w_sum > MAX_V) ? ANGLE_BITS'(MAX_V) : w_sum[ANGLE_BITS-1:0];
    assign w_run_ext = EXT_W'(n_run);
    assign w_run32   = w_run_ext[ANGLE_W-1:0];

    // emitted angle follows the opposite sign of the left sample, zero for zero
    always_comb begin
        if (r_left > 0) begin
            w_angle = -$signed(w_run32);
        end else if (r_left < 0) begin
            w_angle = $signed(w_run32);
        end else begin
            w_angle = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing   <= RST_SPACING;
            r_wait      <= RST_WAIT;
            r_step      <= RST_STEP;
            r_phase     <= PH_IDLE;
            r_left      <= '0;
            r_right     <= '0;
            r_run       <= '0;
            r_tick      <= '0;
            r_seq       <= SQ_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SPACING: r_spacing <= i_cfg_data;
                    CFG_WAIT:    r_wait    <= i_cfg_data;
                    CFG_STEP:    r_step    <= i_cfg_data;
                    default:     r_spacing <= r_spacing;
                endcase
            end

            // result register handshake; the pair result is loaded on accumulate
            if (r_seq == SQ_ACC) begin
                r_out_valid <= 1'b1;
            end else if (w_accept) begin
                r_out_valid <= !w_start;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_right <= n_right;
                r_tick  <= n_tick;
            end

            unique case (r_seq)
                SQ_IDLE: begin
                    if (w_start) begin
                        r_seq <= SQ_DIV;
                        r_cnt <= CNT_W'(DIV_STEPS - 1);
                    end
                end
                SQ_DIV: begin
                    if (r_cnt == '0) begin
                        r_seq <= SQ_SQRT;
                        r_cnt <= CNT_W'(SQRT_STEPS - 1);
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                SQ_SQRT: begin
                    if (r_cnt == '0) begin
                        r_seq <= SQ_MUL;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                SQ_MUL: begin
                    r_seq <= SQ_ACC;
                end
                SQ_ACC: begin
                    r_run <= n_run;
                    r_seq <= SQ_IDLE;
                end
                default: begin
                    r_seq <= SQ_IDLE;
                end
            endcase
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_taken  <= w_taken;
            r_avalid <= 1'b0;
            r_angle  <= '0;
        end

        unique case (r_seq)
            SQ_IDLE: begin
                if (w_start) begin
                    r_quo <= {w_abs[SAMP_W-1:0], FRAC_SH'(0)};
                    r_rem <= '0;
                    r_ws  <= WS_W'(r_wait) * WS_W'(r_step);
                end
            end
            SQ_DIV: begin
                if (r_cnt == '0) begin
                    // divide remainder is not carried into the root
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_rem <= w_res.ge ? w_res.diff : w_req.a;
                end
                r_quo <= {r_quo[DIV_W-2:0], w_res.ge};
            end
            SQ_SQRT: begin
                r_rem  <= w_res.ge ? w_res.diff : w_req.a;
                r_root <= {r_root[ROOT_W-2:0], w_res.ge};
                r_quo  <= {r_quo[DIV_W-3:0], 2'b00};
            end
            SQ_MUL: begin
                r_prod <= PROD_W'(r_root) * PROD_W'(r_ws);
            end
            SQ_ACC: begin
                r_taken  <= 1'b1;
                r_avalid <= 1'b1;
                r_angle  <= w_angle;
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

endmodule
